>>> rtl/core/imm_pkg.sv
// Shared types and constants of the int16 matrix multiply core.
// Holds the control word layout, the microcode table and the item codes.
// No dependencies.
package imm_pkg;

  localparam int STEP_W = 3;
  localparam int DATA_W = 16;

  localparam logic [1:0] KIND_LEFT  = 2'd0;
  localparam logic [1:0] KIND_RIGHT = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [4:0] SIZE_RESET = 5'd16;

  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ISSUE  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DRAIN2 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NO_READ,
    COND_OUTSIDE,
    COND_MORE
  } cond_t;

  typedef struct packed {
    logic              busy;
    logic              clr;
    logic              issue;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic read_go;
    logic outside;
    logic last;
  } flags_t;

  function automatic ctrl_t microcode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{busy: 1'b0, clr: 1'b0, issue: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.cond   = COND_NO_READ;
        w.target = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.busy   = 1'b1;
        w.clr    = 1'b1;
        w.cond   = COND_OUTSIDE;
        w.target = STEP_EMIT;
      end
      STEP_ISSUE: begin
        w.busy   = 1'b1;
        w.issue  = 1'b1;
        w.cond   = COND_MORE;
        w.target = STEP_ISSUE;
      end
      STEP_DRAIN1: begin
        w.busy   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_DRAIN2;
      end
      STEP_DRAIN2: begin
        w.busy   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.busy   = 1'b1;
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/imm_seq.sv
// Microcode sequencer: step counter, control word table and jump logic.
// Depends on imm_pkg.
module imm_seq (
  input  logic            clk,
  input  logic            rst,
  input  imm_pkg::flags_t flags,
  output imm_pkg::ctrl_t  ctrl
);

  logic [imm_pkg::STEP_W-1:0] step;
  logic [imm_pkg::STEP_W-1:0] step_next;
  logic                       take;

  assign ctrl = imm_pkg::microcode(step);

  always_comb begin
    case (ctrl.cond)
      imm_pkg::COND_ALWAYS:  take = 1'b1;
      imm_pkg::COND_NO_READ: take = ~flags.read_go;
      imm_pkg::COND_OUTSIDE: take = flags.outside;
      imm_pkg::COND_MORE:    take = ~flags.last;
      default:               take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= imm_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/core/imm_datapath.sv
// Datapath: matrix stores, index counter, multiply-accumulate and result registers.
// Depends on imm_pkg and imm_ram.
module imm_datapath #(
  parameter int MAX_DIM = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  imm_pkg::ctrl_t      ctrl,
  input  logic                accept,
  input  logic [1:0]          kind,
  input  logic [3:0]          row,
  input  logic [3:0]          col,
  input  logic signed [15:0]  value,
  input  logic [4:0]          active_size,
  output imm_pkg::flags_t     flags,
  output logic                done,
  output logic [3:0]          out_row,
  output logic [3:0]          out_col,
  output logic signed [15:0]  product
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int N_W    = $clog2(MAX_DIM + 1);

  logic [N_W-1:0]    eff;
  logic [3:0]        rd_row;
  logic [3:0]        rd_col;
  logic [IDX_W-1:0]  k;
  logic              in_store;
  logic              we_left;
  logic              we_right;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] left_raddr;
  logic [ADDR_W-1:0] right_raddr;
  logic [15:0]       left_data;
  logic [15:0]       right_data;
  logic              rd_valid;
  logic              mul_valid;
  logic signed [31:0] mul_full;
  logic [15:0]       prod;
  logic [15:0]       acc;

  always_comb begin
    if (32'(active_size) > MAX_DIM) begin
      eff = N_W'(MAX_DIM);
    end else begin
      eff = N_W'(active_size);
    end
    in_store    = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
    we_left     = accept && (kind == imm_pkg::KIND_LEFT) && in_store;
    we_right    = accept && (kind == imm_pkg::KIND_RIGHT) && in_store;
    waddr       = ADDR_W'(32'(row) * MAX_DIM + 32'(col));
    left_raddr  = ADDR_W'(32'(rd_row) * MAX_DIM + 32'(k));
    right_raddr = ADDR_W'(32'(k) * MAX_DIM + 32'(rd_col));
    mul_full    = $signed(left_data) * $signed(right_data);
    flags.read_go = accept && (kind == imm_pkg::KIND_READ);
    flags.outside = !((32'(rd_row) < 32'(eff)) && (32'(rd_col) < 32'(eff)));
    flags.last    = (32'(k) + 32'd1) == 32'(eff);
  end

  imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) u_left (
    .clk  (clk),
    .we   (we_left),
    .waddr(waddr),
    .wdata(value),
    .re   (ctrl.issue),
    .raddr(left_raddr),
    .rdata(left_data)
  );

  imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) u_right (
    .clk  (clk),
    .we   (we_right),
    .waddr(waddr),
    .wdata(value),
    .re   (ctrl.issue),
    .raddr(right_raddr),
    .rdata(right_data)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= row;
      rd_col <= col;
    end
    if (ctrl.clr) begin
      k <= '0;
    end else if (ctrl.issue) begin
      k <= k + 1'b1;
    end
    prod <= mul_full[15:0];
    if (ctrl.clr) begin
      acc <= '0;
    end else if (mul_valid) begin
      acc <= acc + prod;
    end
    if (ctrl.emit) begin
      out_row <= rd_row;
      out_col <= rd_col;
      product <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      rd_valid  <= ctrl.issue;
      mul_valid <= rd_valid;
      done      <= ctrl.emit;
    end
  end

endmodule

>>> rtl/core/int16_matrix_multiply_core.sv
// Top level of the int16 matrix multiply core: size register, sequencer, datapath.
// Depends on imm_pkg, imm_seq and imm_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   command | start, busy          | kind, row, col, value
//   config  | cfg_valid, cfg_ready | cfg_data (active size)
//   result  | done (one cycle)     | out_row, out_col, product
//
// A write beat leaves busy low, and the next beat may follow at once.
// A read in range issues min(active size, MAX_DIM) multiply-accumulates before the done strobe:
// one multiply-accumulate per cycle, bounded by the single read port of each store.
// A read outside the active size returns product 0.
// Reset sets the active size to 16; the stores hold unknown data until written.
// done lasts one cycle and cannot be stalled; a new command beat is taken during it.
module int16_matrix_multiply_core #(
  parameter int MAX_DIM = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [15:0] value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  output logic               done,
  output logic [3:0]         out_row,
  output logic [3:0]         out_col,
  output logic signed [15:0] product
);

  imm_pkg::ctrl_t  ctrl;
  imm_pkg::flags_t flags;
  logic [4:0]      active_size;
  logic            accept;

  assign busy      = ctrl.busy;
  assign cfg_ready = ~ctrl.busy;
  assign accept    = start && !ctrl.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= imm_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_size <= cfg_data;
    end
  end

  imm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .flags(flags),
    .ctrl (ctrl)
  );

  imm_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .accept     (accept),
    .kind       (kind),
    .row        (row),
    .col        (col),
    .value      (value),
    .active_size(active_size),
    .flags      (flags),
    .done       (done),
    .out_row    (out_row),
    .out_col    (out_col),
    .product    (product)
  );

  a_read_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == imm_pkg::KIND_READ) |=> busy)
    else $error("read beat did not start the sequencer");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding busy step");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule
